// ===== rtl/core/acfa_pkg.sv =====
// ----------------------------------------------------------------------------
// acfa_pkg
// shared types and constants of the address cache with fifo aging
// ----------------------------------------------------------------------------
package acfa_pkg;

   localparam int RING_SIZE = 256;
   localparam int IDX_W     = $clog2(RING_SIZE);
   localparam int CNT_W     = IDX_W + 1;
   localparam int KEY_W     = 32;
   localparam int STAMP_W   = 32;
   localparam int DATA_W    = 32;
   localparam int REQ_W     = 104;
   localparam int RSP_W     = 88;

   localparam logic [2:0] MODE_ADD     = 3'd0;
   localparam logic [2:0] MODE_FIND    = 3'd1;
   localparam logic [2:0] MODE_INVAL   = 3'd2;
   localparam logic [2:0] MODE_CLEANUP = 3'd3;
   localparam logic [2:0] MODE_CLEAR   = 3'd4;

   typedef enum logic [2:0] {
      OP_ADD     = 3'd0,
      OP_FIND    = 3'd1,
      OP_INVAL   = 3'd2,
      OP_CLEANUP = 3'd3,
      OP_CLEAR   = 3'd4,
      OP_NONE    = 3'd5
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [KEY_W-1:0]     key;
      logic [STAMP_W-1:0]   stamp;
      logic [DATA_W-1:0]    payload;
   } item_type;

endpackage

// ===== rtl/core/acfa_ram.sv =====
// ----------------------------------------------------------------------------
// acfa_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module acfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/acfa_front.sv =====
// ----------------------------------------------------------------------------
// acfa_front
// accepts request items, decodes the mode and queues them for the engine
// ----------------------------------------------------------------------------
module acfa_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [acfa_pkg::REQ_W-1:0] req_tdata,
   output logic                     q_valid,
   input  logic                     q_ready,
   output acfa_pkg::item_type       q_item
);
   import acfa_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   item_type   dec;
   logic       push, pop;

   always_comb begin
      dec.key     = req_tdata[34:3];
      dec.stamp   = req_tdata[66:35];
      dec.payload = req_tdata[98:67];
      unique case (req_tdata[2:0])
         MODE_ADD:     dec.op = OP_ADD;
         MODE_FIND:    dec.op = OP_FIND;
         MODE_INVAL:   dec.op = OP_INVAL;
         MODE_CLEANUP: dec.op = OP_CLEANUP;
         MODE_CLEAR:   dec.op = OP_CLEAR;
         default:      dec.op = OP_NONE;
      endcase
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign q_valid    = (cnt_ff != 2'd0);
   assign q_item     = slot_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = q_valid && q_ready;
   assign wr_ptr_in  = wr_ptr_ff ^ push;
   assign rd_ptr_in  = rd_ptr_ff ^ pop;
   assign cnt_in     = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

// ===== rtl/core/acfa_engine.sv =====
// ----------------------------------------------------------------------------
// acfa_engine
// sequencer that searches the entry store and walks the reference ring
// ----------------------------------------------------------------------------
module acfa_engine (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   output logic                       q_ready,
   input  acfa_pkg::item_type         q_item,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [acfa_pkg::RSP_W-1:0] rsp_tdata
);
   import acfa_pkg::*;

   typedef enum logic [13:0] {
      S_IDLE     = 14'b00000000000001,
      S_SCAN     = 14'b00000000000010,
      S_DECIDE   = 14'b00000000000100,
      S_ENT_RD   = 14'b00000000001000,
      S_ENT_USE  = 14'b00000000010000,
      S_INC_RD   = 14'b00000000100000,
      S_INC_WR   = 14'b00000001000000,
      S_POP_RD   = 14'b00000010000000,
      S_POP_REF  = 14'b00000100000000,
      S_POP_WR   = 14'b00001000000000,
      S_ALLOC    = 14'b00010000000000,
      S_PUSH_CHK = 14'b00100000000000,
      S_PUSH     = 14'b01000000000000,
      S_RESULT   = 14'b10000000000000
   } state_type;

   state_type            state_ff, state_in;
   item_type             item_ff, item_in;
   logic [CNT_W-1:0]     scan_ff, scan_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]     cmp_idx_ff, cmp_idx_in;
   logic                 match_ff, match_in;
   logic [IDX_W-1:0]     match_idx_ff, match_idx_in;
   logic                 free_ff, free_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;
   logic                 alloc_pend_ff, alloc_pend_in;
   logic                 freed_ff, freed_in;
   logic [IDX_W-1:0]     pop_idx_ff, pop_idx_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [IDX_W-1:0]     tail_ff, tail_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     removed_ff, removed_in;
   logic [RING_SIZE-1:0] valid_ff, valid_in;
   logic                 res_found_ff, res_found_in;
   logic [STAMP_W-1:0]   res_stamp_ff, res_stamp_in;
   logic [DATA_W-1:0]    res_data_ff, res_data_in;

   logic                 key_we, stamp_we, data_we, refs_we, ring_we;
   logic [IDX_W-1:0]     key_wa, stamp_wa, data_wa, refs_wa, ring_wa;
   logic [KEY_W-1:0]     key_wd, key_rd;
   logic [STAMP_W-1:0]   stamp_wd, stamp_rd;
   logic [DATA_W-1:0]    data_wd, data_rd;
   logic [CNT_W-1:0]     refs_wd, refs_rd;
   logic [IDX_W-1:0]     ring_wd, ring_rd;
   logic [IDX_W-1:0]     stamp_ra, refs_ra;
   logic [CNT_W-1:0]     refs_dec;
   logic [IDX_W-1:0]     slot;

   acfa_ram #(.WIDTH(KEY_W), .DEPTH(RING_SIZE)) u_key_ram (
      .clock(clock), .wr_en(key_we), .wr_addr(key_wa), .wr_data(key_wd),
      .rd_addr(scan_ff[IDX_W-1:0]), .rd_data(key_rd));
   acfa_ram #(.WIDTH(STAMP_W), .DEPTH(RING_SIZE)) u_stamp_ram (
      .clock(clock), .wr_en(stamp_we), .wr_addr(stamp_wa), .wr_data(stamp_wd),
      .rd_addr(stamp_ra), .rd_data(stamp_rd));
   acfa_ram #(.WIDTH(DATA_W), .DEPTH(RING_SIZE)) u_data_ram (
      .clock(clock), .wr_en(data_we), .wr_addr(data_wa), .wr_data(data_wd),
      .rd_addr(match_idx_ff), .rd_data(data_rd));
   acfa_ram #(.WIDTH(CNT_W), .DEPTH(RING_SIZE)) u_refs_ram (
      .clock(clock), .wr_en(refs_we), .wr_addr(refs_wa), .wr_data(refs_wd),
      .rd_addr(refs_ra), .rd_data(refs_rd));
   acfa_ram #(.WIDTH(IDX_W), .DEPTH(RING_SIZE)) u_ring_ram (
      .clock(clock), .wr_en(ring_we), .wr_addr(ring_wa), .wr_data(ring_wd),
      .rd_addr(head_ff), .rd_data(ring_rd));

   assign q_ready    = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESULT);
   assign rsp_tdata  = {5'd0, count_ff, removed_ff, res_data_ff, res_stamp_ff, res_found_ff};
   assign refs_dec   = (refs_rd == '0) ? '0 : refs_rd - CNT_W'(1);
   assign slot       = (freed_ff && (!free_ff || pop_idx_ff < free_idx_ff)) ?
                       pop_idx_ff : free_idx_ff;

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      scan_in       = scan_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = scan_ff[IDX_W-1:0];
      match_in      = match_ff;
      match_idx_in  = match_idx_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      alloc_pend_in = alloc_pend_ff;
      freed_in      = freed_ff;
      pop_idx_in    = pop_idx_ff;
      idx_in        = idx_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      removed_in    = removed_ff;
      valid_in      = valid_ff;
      res_found_in  = res_found_ff;
      res_stamp_in  = res_stamp_ff;
      res_data_in   = res_data_ff;
      key_we = 1'b0; key_wa = slot; key_wd = item_ff.key;
      data_we = 1'b0; data_wa = slot; data_wd = item_ff.payload;
      stamp_we = 1'b0; stamp_wa = match_idx_ff; stamp_wd = item_ff.stamp;
      refs_we = 1'b0; refs_wa = match_idx_ff; refs_wd = refs_rd + CNT_W'(1);
      ring_we = 1'b0; ring_wa = tail_ff + IDX_W'(1); ring_wd = idx_ff;
      stamp_ra = match_idx_ff;
      refs_ra  = match_idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               item_in      = q_item;
               scan_in      = '0;
               match_in     = 1'b0;
               free_in      = 1'b0;
               freed_in     = 1'b0;
               removed_in   = '0;
               res_found_in = 1'b0;
               res_stamp_in = '0;
               res_data_in  = '0;
               unique case (q_item.op)
                  OP_ADD, OP_FIND, OP_INVAL: state_in = S_SCAN;
                  OP_CLEANUP, OP_CLEAR:
                     state_in = (count_ff != '0) ? S_POP_RD : S_RESULT;
                  default: state_in = S_RESULT;
               endcase
            end
         end
         S_SCAN: begin
            if (!scan_ff[IDX_W]) begin
               scan_in    = scan_ff + CNT_W'(1);
               cmp_vld_in = 1'b1;
            end
            if (cmp_vld_ff) begin
               if (valid_ff[cmp_idx_ff] && key_rd == item_ff.key && !match_ff) begin
                  match_in     = 1'b1;
                  match_idx_in = cmp_idx_ff;
               end
               if (!valid_ff[cmp_idx_ff] && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = cmp_idx_ff;
               end
               if (cmp_idx_ff == IDX_W'(RING_SIZE - 1)) begin
                  state_in = S_DECIDE;
               end
            end
         end
         S_DECIDE: begin
            priority if (item_ff.op != OP_ADD) begin
               state_in = match_ff ? S_ENT_RD : S_RESULT;
            end else if (match_ff) begin
               state_in = S_INC_RD;
            end else if (count_ff[IDX_W]) begin
               alloc_pend_in = 1'b1;
               state_in      = S_POP_RD;
            end else begin
               state_in = S_ALLOC;
            end
         end
         S_ENT_RD: begin
            state_in = S_ENT_USE;
         end
         S_ENT_USE: begin
            if (item_ff.op == OP_FIND) begin
               res_found_in = 1'b1;
               res_stamp_in = stamp_rd;
               res_data_in  = data_rd;
            end else if (stamp_rd != '0) begin
               stamp_we     = 1'b1;
               stamp_wd     = '0;
               res_found_in = 1'b1;
            end
            state_in = S_RESULT;
         end
         S_INC_RD: begin
            state_in = S_INC_WR;
         end
         S_INC_WR: begin
            refs_we  = 1'b1;
            stamp_we = 1'b1;
            idx_in   = match_idx_ff;
            state_in = S_PUSH_CHK;
         end
         S_POP_RD: begin
            state_in = S_POP_REF;
         end
         S_POP_REF: begin
            stamp_ra   = ring_rd;
            refs_ra    = ring_rd;
            pop_idx_in = ring_rd;
            state_in   = S_POP_WR;
         end
         S_POP_WR: begin
            if (item_ff.op == OP_CLEANUP && stamp_rd > item_ff.stamp) begin
               state_in = S_RESULT;
            end else begin
               refs_we  = 1'b1;
               refs_wa  = pop_idx_ff;
               refs_wd  = refs_dec;
               freed_in = (refs_dec == '0);
               if (refs_dec == '0) begin
                  valid_in[pop_idx_ff] = 1'b0;
               end
               head_in  = head_ff + IDX_W'(1);
               count_in = count_ff - CNT_W'(1);
               if (item_ff.op == OP_ADD) begin
                  alloc_pend_in = 1'b0;
                  state_in      = alloc_pend_ff ? S_ALLOC : S_PUSH;
               end else begin
                  removed_in = removed_ff + CNT_W'(1);
                  state_in   = (count_ff != CNT_W'(1)) ? S_POP_RD : S_RESULT;
               end
            end
         end
         S_ALLOC: begin
            if (freed_ff || free_ff) begin
               key_we         = 1'b1;
               data_we        = 1'b1;
               stamp_we       = 1'b1;
               stamp_wa       = slot;
               refs_we        = 1'b1;
               refs_wa        = slot;
               refs_wd        = CNT_W'(1);
               valid_in[slot] = 1'b1;
               idx_in         = slot;
               state_in       = S_PUSH_CHK;
            end else begin
               state_in = S_RESULT;
            end
         end
         S_PUSH_CHK: begin
            state_in = count_ff[IDX_W] ? S_POP_RD : S_PUSH;
         end
         S_PUSH: begin
            ring_we  = 1'b1;
            tail_in  = tail_ff + IDX_W'(1);
            count_in = count_ff + CNT_W'(1);
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         tail_ff       <= IDX_W'(RING_SIZE - 1);
         count_ff      <= '0;
         valid_ff      <= '0;
         cmp_vld_ff    <= 1'b0;
         alloc_pend_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         valid_ff      <= valid_in;
         cmp_vld_ff    <= cmp_vld_in;
         alloc_pend_ff <= alloc_pend_in;
      end
      item_ff      <= item_in;
      scan_ff      <= scan_in;
      cmp_idx_ff   <= cmp_idx_in;
      match_ff     <= match_in;
      match_idx_ff <= match_idx_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      freed_ff     <= freed_in;
      pop_idx_ff   <= pop_idx_in;
      idx_ff       <= idx_in;
      removed_ff   <= removed_in;
      res_found_ff <= res_found_in;
      res_stamp_ff <= res_stamp_in;
      res_data_ff  <= res_data_in;
   end

endmodule

// ===== rtl/core/address_cache_with_fifo_aging.sv =====
// ----------------------------------------------------------------------------
// address_cache_with_fifo_aging
// address cache with reference counted entries aged through a fifo ring
//
//   port group | dir | fields, lowest bit first
//   req_*      | in  | mode[2:0] key[34:3] stamp[66:35] payload[98:67]
//   rsp_*      | out | found[0] found_stamp[32:1] found_data[64:33]
//              |     | removed_count[73:65] ring_fill[82:74]
//
// add, find and invalidate scan all 256 entries of the key ram; cleanup and clear
// pop references from the ring head, cleanup stopping at the first reference whose
// entry stamp is later than the request stamp.
// the two-deep request queue takes items while a response waits.
// synchronous active-high reset clears entry valid bits and ring fill and resets ring pointers.
// ----------------------------------------------------------------------------
module address_cache_with_fifo_aging (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [acfa_pkg::REQ_W-1:0] req_tdata,  // mode, key, stamp, payload
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [acfa_pkg::RSP_W-1:0] rsp_tdata   // found, found_stamp, found_data,
                                                  // removed_count, ring_fill
);
   import acfa_pkg::*;

   logic     q_valid;
   logic     q_ready;
   item_type q_item;

   acfa_front u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item));

   acfa_engine u_engine (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));

endmodule
